// File: src/tc2a_pkg.sv
package tc2a_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;
    localparam int COL_W           = 7;
    localparam int ROW_W           = 5;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // segment order of one cell's output
    localparam int SEG_PEND   = 0;
    localparam int SEG_COLOUR = 1;
    localparam int SEG_CHAR   = 2;
    localparam int SEG_EOL    = 3;
    localparam int SEG_FIN    = 4;
    localparam int SEG_N      = 5;

    typedef logic [2:0] t_seg;

    typedef struct packed {
        logic       pend;
        logic       colour;
        logic [2:0] bg;
        logic [3:0] fg;
        logic [1:0] ch_len;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
        logic       eol;
        logic       fin;
    } t_desc;

    localparam logic [15:0] HIGH_GLYPH [128] = '{
        16'h00C7,16'h00FC,16'h00E9,16'h00E2,16'h00E4,16'h00E0,16'h00E5,16'h00E7,
        16'h00EA,16'h00EB,16'h00E8,16'h00EF,16'h00EE,16'h00EC,16'h00C4,16'h00C5,
        16'h00C9,16'h00E6,16'h00C6,16'h00F4,16'h00F6,16'h00F2,16'h00FB,16'h00F9,
        16'h00FF,16'h00D6,16'h00DC,16'h00A2,16'h00A3,16'h00A5,16'h20A7,16'h0192,
        16'h00E1,16'h00ED,16'h00F3,16'h00FA,16'h00F1,16'h00D1,16'h00AA,16'h00BA,
        16'h00BF,16'h2310,16'h00AC,16'h00BD,16'h00BC,16'h00A1,16'h00AB,16'h00BB,
        16'h2591,16'h2592,16'h2593,16'h2502,16'h2524,16'h2561,16'h2562,16'h2556,
        16'h2555,16'h2563,16'h2551,16'h2557,16'h255D,16'h255C,16'h255B,16'h2510,
        16'h2514,16'h2534,16'h252C,16'h251C,16'h2500,16'h253C,16'h255E,16'h255F,
        16'h255A,16'h2554,16'h2569,16'h2566,16'h2560,16'h2550,16'h256C,16'h2567,
        16'h2568,16'h2564,16'h2565,16'h2559,16'h2558,16'h2552,16'h2553,16'h256B,
        16'h256A,16'h2518,16'h250C,16'h2588,16'h2584,16'h258C,16'h2590,16'h2580,
        16'h03B1,16'h00DF,16'h0393,16'h03C0,16'h03A3,16'h03C3,16'h00B5,16'h03C4,
        16'h03A6,16'h0398,16'h03A9,16'h03B4,16'h221E,16'h03C6,16'h03B5,16'h2229,
        16'h2261,16'h00B1,16'h2265,16'h2264,16'h2320,16'h2321,16'h00F7,16'h2248,
        16'h00B0,16'h2219,16'h00B7,16'h221A,16'h207F,16'h00B2,16'h25A0,16'h00A0
    };

    function automatic logic [7:0] ansi_digit(input logic [2:0] idx);
        logic [7:0] d;
        case (idx)
            3'd0: d = 8'h30;
            3'd1: d = 8'h34;
            3'd2: d = 8'h32;
            3'd3: d = 8'h36;
            3'd4: d = 8'h31;
            3'd5: d = 8'h35;
            3'd6: d = 8'h33;
            default: d = 8'h37;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] ascii_sub(input logic [7:0] c);
        logic [7:0] s;
        case (c) inside
            8'hc4: s = 8'h2d;
            8'hcd, 8'hbc, 8'hbb, 8'hcb, 8'hc8, 8'hc9: s = 8'h3d;
            8'hba: s = 8'h48;
            8'hb0: s = 8'h25;
            8'hb2: s = 8'h23;
            8'hb1: s = 8'h26;
            8'hdb: s = 8'h4d;
            default: s = CH_SPACE;
        endcase
        return s;
    endfunction

endpackage

// File: src/tc2a_front.sv
module tc2a_front #(
    parameter int COLUMNS = tc2a_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tc2a_pkg::ROWS_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_push,
    input  logic [7:0]      i_char_code,
    input  logic [7:0]      i_attribute,
    output tc2a_pkg::t_desc o_desc
);

    logic                       r_unicode;
    logic [tc2a_pkg::COL_W-1:0] r_col;
    logic [tc2a_pkg::ROW_W-1:0] r_row;
    logic                       r_known;
    logic [3:0]                 r_fg;
    logic [2:0]                 r_bg;
    logic                       r_pend;

    logic [3:0]  fg;
    logic [2:0]  bg;
    logic        chg;
    logic        col_end;
    logic        row_end;
    logic [15:0] cp;
    logic [4:0]  cnt;
    logic        fits;

    assign fg      = i_attribute[3:0];
    assign bg      = i_attribute[6:4];
    assign chg     = !r_known || (fg != r_fg) || (bg != r_bg);
    assign col_end = ({1'b0, r_col} + 8'd1) >= 8'(COLUMNS);
    assign row_end = col_end && (({1'b0, r_row} + 6'd1) >= 6'(ROWS));
    assign cp      = tc2a_pkg::HIGH_GLYPH[i_char_code[6:0]];

    always_comb begin
        o_desc        = '0;
        o_desc.pend   = r_pend;
        o_desc.colour = chg;
        o_desc.bg     = bg;
        o_desc.fg     = fg;
        o_desc.eol    = col_end;
        if (!i_char_code[7]) begin
            o_desc.ch_len = 2'd1;
            o_desc.ch0    = i_char_code;
        end else if (!r_unicode) begin
            o_desc.ch_len = 2'd1;
            o_desc.ch0    = tc2a_pkg::ascii_sub(i_char_code);
        end else if (cp < 16'h0800) begin
            o_desc.ch_len = 2'd2;
            o_desc.ch0    = {3'b110, cp[10:6]};
            o_desc.ch1    = {2'b10, cp[5:0]};
        end else begin
            o_desc.ch_len = 2'd3;
            o_desc.ch0    = {4'b1110, cp[15:12]};
            o_desc.ch1    = {2'b10, cp[11:6]};
            o_desc.ch2    = {2'b10, cp[5:0]};
        end
        cnt = (r_pend ? 5'd4 : 5'd0)
            + (chg ? ((bg == 3'd0) ? 5'd9 : 5'd8) : 5'd0)
            + {3'd0, o_desc.ch_len} + 5'd5;
        fits       = cnt <= 5'd14;
        o_desc.fin = row_end && fits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unicode <= 1'b1;
            r_col     <= '0;
            r_row     <= '0;
            r_known   <= 1'b0;
            r_fg      <= '0;
            r_bg      <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_unicode <= i_cfg_wdata;
            end
            if (i_push) begin
                r_col   <= col_end ? '0 : r_col + 1'b1;
                if (col_end) begin
                    r_row <= row_end ? '0 : r_row + 1'b1;
                end
                r_known <= !row_end;
                r_fg    <= fg;
                r_bg    <= bg;
                r_pend  <= row_end && !fits;
            end
        end
    end

endmodule

// File: src/tc2a_queue.sv
module tc2a_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tc2a_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output tc2a_pkg::t_desc o_desc
);

    localparam int AW = $clog2(tc2a_pkg::QUEUE_DEPTH);

    tc2a_pkg::t_desc r_mem [tc2a_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = r_cnt == (AW+1)'(tc2a_pkg::QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_desc  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("request pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(tc2a_pkg::QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: src/tc2a_back.sv
module tc2a_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  tc2a_pkg::t_desc i_desc,
    output logic            o_pop,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last,
    input  logic            i_ready
);

    logic [tc2a_pkg::SEG_N-1:0] en;
    logic [tc2a_pkg::SEG_N-1:0] above;
    tc2a_pkg::t_seg             r_seg;
    logic [3:0]                 r_idx;
    logic                       r_valid;
    logic [7:0]                 r_byte;
    logic                       r_last;

    tc2a_pkg::t_seg seg;
    logic [3:0]     len;
    logic [7:0]     byte_n;
    logic [7:0]     rst_byte;
    logic [7:0]     f1;
    logic [7:0]     f2;
    logic           seg_end;
    logic           last;
    logic           adv;
    logic           step;

    assign en = {i_desc.fin, i_desc.eol, 1'b1, i_desc.colour, i_desc.pend};

    always_comb begin
        seg   = tc2a_pkg::t_seg'(tc2a_pkg::SEG_CHAR);
        above = '0;
        for (int k = tc2a_pkg::SEG_N - 1; k >= 0; k--) begin
            if (en[k] && (3'(k) >= r_seg)) begin
                seg = 3'(k);
            end
        end
        for (int k = 0; k < tc2a_pkg::SEG_N; k++) begin
            above[k] = en[k] && (3'(k) > seg);
        end
    end

    assign f1 = i_desc.fg[3] ? tc2a_pkg::CH_NINE : tc2a_pkg::CH_THREE;
    assign f2 = tc2a_pkg::ansi_digit(i_desc.fg[2:0]);

    always_comb begin
        case (r_idx)
            4'd0:    rst_byte = tc2a_pkg::CH_ESC;
            4'd1:    rst_byte = tc2a_pkg::CH_LBRK;
            4'd2:    rst_byte = tc2a_pkg::CH_ZERO;
            4'd3:    rst_byte = tc2a_pkg::CH_M;
            default: rst_byte = tc2a_pkg::CH_LF;
        endcase
        len    = 4'd4;
        byte_n = rst_byte;
        case (seg)
            3'(tc2a_pkg::SEG_COLOUR): begin
                if (i_desc.bg == 3'd0) begin
                    len = 4'd9;
                    case (r_idx)
                        4'd4:    byte_n = tc2a_pkg::CH_ESC;
                        4'd5:    byte_n = tc2a_pkg::CH_LBRK;
                        4'd6:    byte_n = f1;
                        4'd7:    byte_n = f2;
                        4'd8:    byte_n = tc2a_pkg::CH_M;
                        default: byte_n = rst_byte;
                    endcase
                end else begin
                    len = 4'd8;
                    case (r_idx)
                        4'd0:    byte_n = tc2a_pkg::CH_ESC;
                        4'd1:    byte_n = tc2a_pkg::CH_LBRK;
                        4'd2:    byte_n = tc2a_pkg::CH_FOUR;
                        4'd3:    byte_n = tc2a_pkg::ansi_digit(i_desc.bg);
                        4'd4:    byte_n = tc2a_pkg::CH_SEMI;
                        4'd5:    byte_n = f1;
                        4'd6:    byte_n = f2;
                        default: byte_n = tc2a_pkg::CH_M;
                    endcase
                end
            end
            3'(tc2a_pkg::SEG_CHAR): begin
                len = {2'b00, i_desc.ch_len};
                case (r_idx)
                    4'd0:    byte_n = i_desc.ch0;
                    4'd1:    byte_n = i_desc.ch1;
                    default: byte_n = i_desc.ch2;
                endcase
            end
            3'(tc2a_pkg::SEG_EOL): begin
                len = 4'd5;
            end
            default: begin
                len = 4'd4;
            end
        endcase
    end

    assign seg_end = r_idx == (len - 4'd1);
    assign last    = seg_end && (above == '0);
    assign adv     = !r_valid || i_ready;
    assign step    = adv && !i_empty;
    assign o_pop   = step && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg   <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_valid <= !i_empty;
            end
            if (step) begin
                if (last) begin
                    r_seg <= '0;
                    r_idx <= '0;
                end else if (seg_end) begin
                    r_seg <= seg + 3'd1;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= byte_n;
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

// File: src/text_cell_to_ansi_utf8_encoder.sv
// Text-mode cell to ANSI/UTF-8 terminal stream encoder. Each accepted cell
// (code page 437 char, attribute) expands to 1..18 output bytes, one byte per
// clock on the master side while tready is high; the byte sequencer sets the
// pace, emitting a cell's bytes in turn (typically 1..3, up to 18 at a colour
// change at end of screen). A 4-entry request queue sits between the cell
// classifier and the byte sequencer, so cells keep being accepted, one per
// cycle while the queue has room, as earlier bytes drain. tlast marks the final
// byte of each cell. The UTF-8 enable bit (reset 1) is written through
// i_cfg_we/i_cfg_wdata; the user must do so only while idle (not enforced).
module text_cell_to_ansi_utf8_encoder #(
    parameter int COLUMNS = tc2a_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tc2a_pkg::ROWS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [7:0] char_code, [15:8] attribute
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [7:0] out_byte
    output logic        o_m_tlast
);

    tc2a_pkg::t_desc push_desc;
    tc2a_pkg::t_desc head_desc;
    logic            full;
    logic            empty;
    logic            push;
    logic            pop;

    assign o_s_tready = !full;
    assign push       = i_s_tvalid && !full;

    tc2a_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_char_code (i_s_tdata[7:0]),
        .i_attribute (i_s_tdata[15:8]),
        .o_desc      (push_desc)
    );

    tc2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_desc  (head_desc)
    );

    tc2a_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_desc  (head_desc),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast),
        .i_ready (i_m_tready)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int COLS = tc2a_pkg::COLUMNS_DEFAULT;
    localparam int ROWS = tc2a_pkg::ROWS_DEFAULT;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [15:0] i_s_tdata = '0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;

    text_cell_to_ansi_utf8_encoder dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // encoder mirror state
    logic       m_unicode = 1'b1;
    logic [6:0] m_col = '0;
    logic [4:0] m_row = '0;
    logic       m_known = 1'b0;
    logic [3:0] m_fg = '0;
    logic [2:0] m_bg = '0;
    logic       m_pend = 1'b0;

    logic [8:0] expected_bytes[$];  // {last, byte}
    logic [7:0] cell_bytes[$];
    int errors = 0;
    int hold_off = 0;
    bit stall_pattern = 1'b1;

    function automatic logic [7:0] sgr_digit(input logic [2:0] i);
        logic [7:0] t[8];
        t = '{8'h30, 8'h34, 8'h32, 8'h36, 8'h31, 8'h35, 8'h33, 8'h37};
        return t[i];
    endfunction

    function automatic logic [7:0] box_substitute(input logic [7:0] c);
        logic [7:0] r;
        r = tc2a_pkg::CH_SPACE;
        if (c == 8'hc4) r = "-";
        if (c == 8'hcd || c == 8'hbc || c == 8'hbb || c == 8'hcb || c == 8'hc8 || c == 8'hc9)
            r = "=";
        if (c == 8'hba) r = "H";
        if (c == 8'hb0) r = "%";
        if (c == 8'hb2) r = "#";
        if (c == 8'hb1) r = "&";
        if (c == 8'hdb) r = "M";
        return r;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        if (cell_bytes.size() < 18) cell_bytes.push_back(b);
    endtask

    task automatic put_reset();
        put_byte(tc2a_pkg::CH_ESC); put_byte(tc2a_pkg::CH_LBRK);
        put_byte(tc2a_pkg::CH_ZERO); put_byte(tc2a_pkg::CH_M);
    endtask

    task automatic put_fg(input logic [3:0] f);
        put_byte(f[3] ? tc2a_pkg::CH_NINE : tc2a_pkg::CH_THREE);
        put_byte(sgr_digit(f[2:0]));
    endtask

    task automatic encode_cell(input logic [7:0] c, input logic [7:0] a);
        logic [3:0] f;
        logic [2:0] g;
        logic [15:0] cp;
        f = a[3:0];
        g = a[6:4];
        cell_bytes.delete();
        if (m_pend) begin
            put_reset();
            m_pend = 1'b0;
        end
        if (!m_known || f != m_fg || g != m_bg) begin
            m_known = 1'b1; m_fg = f; m_bg = g;
            if (g == 0) begin
                put_reset();
                put_byte(tc2a_pkg::CH_ESC); put_byte(tc2a_pkg::CH_LBRK);
                put_fg(f); put_byte(tc2a_pkg::CH_M);
            end else begin
                put_byte(tc2a_pkg::CH_ESC); put_byte(tc2a_pkg::CH_LBRK);
                put_byte(tc2a_pkg::CH_FOUR); put_byte(sgr_digit(g));
                put_byte(tc2a_pkg::CH_SEMI); put_fg(f); put_byte(tc2a_pkg::CH_M);
            end
        end
        if (!c[7]) put_byte(c);
        else if (!m_unicode) put_byte(box_substitute(c));
        else begin
            cp = tc2a_pkg::HIGH_GLYPH[c[6:0]];
            if (cp < 16'h800) begin
                put_byte({3'b110, cp[10:6]});
                put_byte({2'b10, cp[5:0]});
            end else begin
                put_byte({4'b1110, cp[15:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
        end
        if (int'(m_col) + 1 >= COLS) begin
            m_col = '0;
            put_reset();
            put_byte(tc2a_pkg::CH_LF);
            if (int'(m_row) + 1 >= ROWS) begin
                m_row = '0;
                m_known = 1'b0;
                if (cell_bytes.size() + 4 <= 18) put_reset();
                else m_pend = 1'b1;
            end else m_row = m_row + 5'd1;
        end else m_col = m_col + 7'd1;
        foreach (cell_bytes[k])
            expected_bytes.push_back({k == cell_bytes.size() - 1, cell_bytes[k]});
    endtask

    // sends one request; bursts with random gaps
    int burst_left = 0;
    task automatic send_cell(input logic [7:0] c, input logic [7:0] a);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {a, c};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        encode_cell(c, a);
        burst_left--;
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else if (stall_pattern) i_m_tready <= ($urandom_range(0, 3) != 0);
        else i_m_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        logic [8:0] e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected byte %h last %b", o_m_tdata, o_m_tlast);
            end else begin
                e = expected_bytes.pop_front();
                if (e[7:0] !== o_m_tdata || e[8] !== o_m_tlast) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h last %b, got %h last %b",
                                 e[7:0], e[8], o_m_tdata, o_m_tlast);
                end
            end
        end
    end

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_unicode(input logic v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_unicode = v;
    endtask

    task automatic test_directed();
        send_cell(8'h00, 8'h00);
        send_cell(8'h7f, 8'h0f);
        send_cell(8'hff, 8'hff);
        send_cell(8'h80, 8'h70);
        send_cell(8'h9e, 8'h60);
        send_cell(8'hc4, 8'h8f);
        send_cell(8'h41, 8'h8f);
        send_cell(8'h0a, 8'h1b);
        send_cell(8'hb0, 8'h07);
        set_unicode(1'b0);
        for (int c = 8'hb0; c <= 8'hdb; c++) send_cell(c[7:0], 8'h07);
        send_cell(8'hff, 8'h55);
        send_cell(8'h80, 8'h55);
        set_unicode(1'b1);
    endtask

    task automatic test_row_end();
        // fill the current row, then close it on a colour change
        while (int'(m_col) != COLS - 1)
            send_cell(8'($urandom_range(0, 255)), 8'h07);
        send_cell(8'hb2, 8'h7f);
        send_cell(8'h41, 8'h7f);
    endtask

    task automatic test_random();
        for (int n = 0; n < 250; n++) begin
            if (n == 90) set_unicode(1'b0);
            if (n == 170) set_unicode(1'b1);
            if (n == 40) hold_off = 300;
            send_cell(8'($urandom_range(0, 255)),
                      ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'h1e);
            if (n == 140) stall_pattern = 1'b0;
            if (n == 200) stall_pattern = 1'b1;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_row_end();
        drain();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: text_cell_to_ansi_utf8_encoder.f
src/tc2a_pkg.sv
src/tc2a_front.sv
src/tc2a_queue.sv
src/tc2a_back.sv
src/text_cell_to_ansi_utf8_encoder.sv
bench/testbench.sv
